[rtl/plca_control_fsm_assert.svh]
// Assertion macros used by the PLCA control RTL.
`ifndef PLCA_CONTROL_FSM_ASSERT_SVH
`define PLCA_CONTROL_FSM_ASSERT_SVH

// Checked while out of reset.
`define PLCA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define PLCA_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/plca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package plca_pkg;

  localparam logic [3:0] ST_DISABLE       = 4'd0;
  localparam logic [3:0] ST_RESYNC        = 4'd1;
  localparam logic [3:0] ST_RECOVER       = 4'd2;
  localparam logic [3:0] ST_BEACON_TX     = 4'd3;
  localparam logic [3:0] ST_SYNCING       = 4'd4;
  localparam logic [3:0] ST_WAIT_TO       = 4'd5;
  localparam logic [3:0] ST_EARLY_RECEIVE = 4'd6;
  localparam logic [3:0] ST_COMMIT        = 4'd7;
  localparam logic [3:0] ST_YIELD         = 4'd8;
  localparam logic [3:0] ST_RECEIVE       = 4'd9;
  localparam logic [3:0] ST_TRANSMIT      = 4'd10;
  localparam logic [3:0] ST_BURST         = 4'd11;
  localparam logic [3:0] ST_NEXT_TXOP     = 4'd12;
  localparam logic [3:0] ST_ABORT         = 4'd13;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_BEACON = 2'd1;
  localparam logic [1:0] CMD_COMMIT = 2'd2;

  localparam int NUM_TIMERS = 4;
  localparam int TM_BEACON  = 0;
  localparam int TM_TO      = 1;
  localparam int TM_BURST   = 2;
  localparam int TM_BDET    = 3;

  localparam logic [2:0] REG_LOCAL_NODE_ID    = 3'd0;
  localparam logic [2:0] REG_NODE_COUNT       = 3'd1;
  localparam logic [2:0] REG_MAX_BURST        = 3'd2;
  localparam logic [2:0] REG_TO_TICKS         = 3'd3;
  localparam logic [2:0] REG_BEACON_TICKS     = 3'd4;
  localparam logic [2:0] REG_BURST_TICKS      = 3'd5;
  localparam logic [2:0] REG_BEACON_DET_TICKS = 3'd6;
  localparam logic [2:0] REG_PLCA_ENABLE      = 3'd7;

  localparam logic [7:0] ID_DISABLED = 8'hFF;
  localparam logic [7:0] ID_COORD    = 8'h00;
  localparam logic [7:0] COUNT_MAX   = 8'hFF;

  typedef struct packed {
    logic [NUM_TIMERS-1:0] start;
    logic [NUM_TIMERS-1:0] stop;
  } tmr_ctl_t;

endpackage

`default_nettype wire

[rtl/plca_timers.sv]
`timescale 1ns / 1ps
`default_nettype none

module plca_timers #(
  parameter int TIMER_BITS = 16
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             step,
  input  plca_pkg::tmr_ctl_t                               ctl,
  input  logic [plca_pkg::NUM_TIMERS-1:0][TIMER_BITS-1:0] len,
  output logic [plca_pkg::NUM_TIMERS-1:0]                 done
);
  import plca_pkg::*;

  localparam logic [TIMER_BITS-1:0] ONE = TIMER_BITS'(1);

  logic [TIMER_BITS-1:0] count      [NUM_TIMERS];
  logic [TIMER_BITS-1:0] count_next [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] running;
  logic [NUM_TIMERS-1:0] running_next;
  logic [TIMER_BITS-1:0] count_tick [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] run_tick;

  // a running count is never zero, so it stops when it leaves one
  always_comb begin
    for (int t = 0; t < NUM_TIMERS; t++) begin
      count_tick[t] = running[t] ? count[t] - ONE : count[t];
      run_tick[t]   = running[t] && (count[t] != ONE);
      done[t]       = !run_tick[t];
      if (ctl.start[t]) begin
        count_next[t]   = len[t];
        running_next[t] = |len[t];
      end else if (ctl.stop[t]) begin
        count_next[t]   = count_tick[t];
        running_next[t] = 1'b0;
      end else begin
        count_next[t]   = count_tick[t];
        running_next[t] = run_tick[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count[t] <= '0;
      end
    end else if (step) begin
      running <= running_next;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count[t] <= count_next[t];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/plca_control_fsm.sv]
// Channel  | Handshake           | Beat
// input    | in_valid/in_ready   | reset_req .. pmcd, one line clock tick
// result   | out_valid/out_ready | out_state .. out_cur_id, state after the tick
// config   | cfg_we              | cfg_index, cfg_data
//
// One beat per cycle unless a result stalls: a tick is held in the input register,
// then one pass of next-state logic updates the machine and the four timers.
// The machine registers are the result register; a result waiting on
// out_ready stalls the input register, which still takes one more beat.
// Synchronous reset: no beats held, machine in DISABLE, timers stopped,
// config at its defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "plca_control_fsm_assert.svh"

module plca_control_fsm #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        reset_req,
  input  logic        carrier_sense,
  input  logic        tx_enable,
  input  logic        packet_pending,
  input  logic        receiving,
  input  logic        rx_beacon,
  input  logic        pmcd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_state,
  output logic [1:0]  out_tx_cmd,
  output logic        out_committed,
  output logic        out_active,
  output logic [7:0]  out_cur_id,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import plca_pkg::*;

  // configuration
  logic [7:0]  local_node_id;
  logic [7:0]  node_count;
  logic [7:0]  max_burst;
  logic [15:0] to_ticks;
  logic [15:0] beacon_ticks;
  logic [15:0] burst_ticks;
  logic [15:0] beacon_det_ticks;
  logic        plca_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_node_id    <= ID_DISABLED;
      node_count       <= 8'd8;
      max_burst        <= 8'd0;
      to_ticks         <= 16'd32;
      beacon_ticks     <= 16'd20;
      burst_ticks      <= 16'd128;
      beacon_det_ticks <= 16'd22;
      plca_enable      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_NODE_ID:    local_node_id    <= cfg_data[7:0];
        REG_NODE_COUNT:       node_count       <= cfg_data[7:0];
        REG_MAX_BURST:        max_burst        <= cfg_data[7:0];
        REG_TO_TICKS:         to_ticks         <= cfg_data;
        REG_BEACON_TICKS:     beacon_ticks     <= cfg_data;
        REG_BURST_TICKS:      burst_ticks      <= cfg_data;
        REG_BEACON_DET_TICKS: beacon_det_ticks <= cfg_data;
        REG_PLCA_ENABLE:      plca_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  logic in_vld;
  logic r_reset_req, r_crs, r_txen, r_pend, r_rcv, r_bcn, r_pmcd;
  logic proceed;

  assign proceed  = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_reset_req <= reset_req;
      r_crs       <= carrier_sense;
      r_txen      <= tx_enable;
      r_pend      <= packet_pending;
      r_rcv       <= receiving;
      r_bcn       <= rx_beacon;
      r_pmcd      <= pmcd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // machine state
  logic [3:0] state, state_next;
  logic [7:0] current_id, current_id_next;
  logic [7:0] burst_count, burst_count_next;
  logic       active_flag, active_flag_next;
  logic       committed_flag, committed_flag_next;
  logic [1:0] tx_command, tx_command_next;
  logic       reset_seen, reset_seen_next;

  tmr_ctl_t                              tmr_ctl;
  logic [NUM_TIMERS-1:0][TIMER_BITS-1:0] tmr_len;
  logic [NUM_TIMERS-1:0]                 tmr_done;

  assign tmr_len[TM_BEACON] = TIMER_BITS'(beacon_ticks);
  assign tmr_len[TM_TO]     = TIMER_BITS'(to_ticks);
  assign tmr_len[TM_BURST]  = TIMER_BITS'(burst_ticks);
  assign tmr_len[TM_BDET]   = TIMER_BITS'(beacon_det_ticks);

  plca_timers #(
    .TIMER_BITS(TIMER_BITS)
  ) u_timers (
    .clk  (clk),
    .rst  (rst),
    .step (proceed),
    .ctl  (tmr_ctl),
    .len  (tmr_len),
    .done (tmr_done)
  );

  logic       forced, nid0, take;
  logic [3:0] ns;

  assign forced = r_reset_req || !plca_enable || (local_node_id == ID_DISABLED);
  assign nid0   = (local_node_id == ID_COORD);

  // transition
  always_comb begin
    take            = 1'b0;
    ns              = state;
    reset_seen_next = reset_seen;
    tmr_ctl         = '0;
    if (forced) begin
      take = 1'b1;
      ns   = ST_DISABLE;
      if (!reset_seen) begin
        reset_seen_next         = 1'b1;
        tmr_ctl.stop[TM_BEACON] = 1'b1;
        tmr_ctl.stop[TM_BURST]  = 1'b1;
        tmr_ctl.stop[TM_TO]     = 1'b1;
      end
    end else begin
      reset_seen_next = 1'b0;
      case (state)
        ST_DISABLE: begin
          take = 1'b1;
          ns   = nid0 ? ST_RECOVER : ST_RESYNC;
        end
        ST_RESYNC: begin
          if (nid0) begin
            if (!r_crs && r_pmcd) begin
              take = 1'b1;
              ns   = ST_BEACON_TX;
            end
          end else if (r_crs) begin
            take = 1'b1;
            ns   = ST_EARLY_RECEIVE;
          end
        end
        ST_RECOVER: begin
          take = 1'b1;
          ns   = ST_WAIT_TO;
        end
        ST_BEACON_TX: begin
          if (tmr_done[TM_BEACON]) begin
            take = 1'b1;
            ns   = ST_SYNCING;
          end
        end
        ST_SYNCING: begin
          if (!r_crs) begin
            take = 1'b1;
            ns   = ST_WAIT_TO;
          end
        end
        ST_WAIT_TO: begin
          if (r_crs) begin
            take = 1'b1;
            ns   = ST_EARLY_RECEIVE;
          end else if (local_node_id == current_id) begin
            take = 1'b1;
            ns   = (r_pend && active_flag) ? ST_COMMIT : ST_YIELD;
          end else if (tmr_done[TM_TO]) begin
            take = 1'b1;
            ns   = ST_NEXT_TXOP;
          end
        end
        ST_EARLY_RECEIVE: begin
          if (r_crs) begin
            if (r_rcv) begin
              take = 1'b1;
              ns   = ST_RECEIVE;
            end else if (!nid0 && r_bcn) begin
              take = 1'b1;
              ns   = ST_SYNCING;
            end
          end else if (nid0) begin
            take = 1'b1;
            ns   = ST_RECEIVE;
          end else if (r_bcn || !tmr_done[TM_BDET]) begin
            if (r_rcv) begin
              take = 1'b1;
              ns   = ST_SYNCING;
            end
          end else begin
            take = 1'b1;
            ns   = ST_RESYNC;
          end
        end
        ST_COMMIT: begin
          if (r_txen) begin
            take = 1'b1;
            ns   = ST_TRANSMIT;
          end else if (!r_pend) begin
            take = 1'b1;
            ns   = ST_ABORT;
          end
        end
        ST_YIELD: begin
          if (tmr_done[TM_TO]) begin
            take = 1'b1;
            ns   = ST_NEXT_TXOP;
          end else if (r_crs) begin
            take = 1'b1;
            ns   = ST_EARLY_RECEIVE;
          end
        end
        ST_RECEIVE, ST_ABORT: begin
          if (!r_crs) begin
            take = 1'b1;
            ns   = ST_NEXT_TXOP;
          end
        end
        ST_TRANSMIT: begin
          if (!r_txen) begin
            if (burst_count < max_burst) begin
              take = 1'b1;
              ns   = ST_BURST;
            end else if (!r_crs) begin
              take = 1'b1;
              ns   = ST_NEXT_TXOP;
            end
          end
        end
        ST_BURST: begin
          if (r_txen) begin
            take = 1'b1;
            ns   = ST_TRANSMIT;
          end else if (tmr_done[TM_BURST]) begin
            take = 1'b1;
            ns   = ST_ABORT;
          end
        end
        ST_NEXT_TXOP: begin
          take = 1'b1;
          if ((nid0 && current_id >= node_count) || current_id == ID_DISABLED) begin
            ns = ST_RESYNC;
          end else begin
            ns = ST_WAIT_TO;
          end
        end
        default: begin
          take = 1'b1;
          ns   = ST_DISABLE;
        end
      endcase
    end

    // entry actions, run on every transition taken
    state_next          = state;
    current_id_next     = current_id;
    burst_count_next    = burst_count;
    active_flag_next    = active_flag;
    committed_flag_next = committed_flag;
    tx_command_next     = tx_command;
    if (take) begin
      state_next = ns;
      case (ns)
        ST_DISABLE: begin
          committed_flag_next = 1'b0;
          tx_command_next     = CMD_NONE;
          active_flag_next    = 1'b0;
          current_id_next     = '0;
        end
        ST_RESYNC, ST_RECOVER: begin
          active_flag_next = 1'b0;
        end
        ST_BEACON_TX: begin
          tmr_ctl.start[TM_BEACON] = 1'b1;
          tx_command_next          = CMD_BEACON;
          active_flag_next         = 1'b1;
        end
        ST_SYNCING: begin
          tx_command_next  = CMD_NONE;
          active_flag_next = 1'b1;
          current_id_next  = '0;
        end
        ST_WAIT_TO: begin
          tmr_ctl.start[TM_TO] = 1'b1;
        end
        ST_EARLY_RECEIVE: begin
          tmr_ctl.stop[TM_TO]    = 1'b1;
          tmr_ctl.start[TM_BDET] = 1'b1;
        end
        ST_COMMIT: begin
          tmr_ctl.stop[TM_TO] = 1'b1;
          tx_command_next     = CMD_COMMIT;
          committed_flag_next = 1'b1;
          burst_count_next    = '0;
        end
        ST_TRANSMIT: begin
          tx_command_next = CMD_NONE;
          if (burst_count >= max_burst) begin
            committed_flag_next = 1'b0;
          end
        end
        ST_BURST: begin
          if (burst_count != COUNT_MAX) begin
            burst_count_next = burst_count + 8'd1;
          end
          tx_command_next         = CMD_COMMIT;
          tmr_ctl.start[TM_BURST] = 1'b1;
        end
        ST_NEXT_TXOP: begin
          if (current_id != COUNT_MAX) begin
            current_id_next = current_id + 8'd1;
          end
          committed_flag_next = 1'b0;
        end
        ST_ABORT: begin
          tx_command_next = CMD_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_DISABLE;
      current_id     <= '0;
      burst_count    <= '0;
      active_flag    <= 1'b0;
      committed_flag <= 1'b0;
      tx_command     <= CMD_NONE;
      reset_seen     <= 1'b0;
    end else if (proceed) begin
      state          <= state_next;
      current_id     <= current_id_next;
      burst_count    <= burst_count_next;
      active_flag    <= active_flag_next;
      committed_flag <= committed_flag_next;
      tx_command     <= tx_command_next;
      reset_seen     <= reset_seen_next;
    end
  end

  assign out_state     = state;
  assign out_tx_cmd    = tx_command;
  assign out_committed = committed_flag;
  assign out_active    = active_flag;
  assign out_cur_id    = current_id;

  `PLCA_CHECK_ALWAYS(a_rst_empty, rst |=> !out_valid && !in_vld, "beat held after reset")
  `PLCA_CHECK(a_state_legal, state <= ST_ABORT, "state code out of range")
  `PLCA_CHECK(a_hold, !proceed |=> $stable(state) && $stable(current_id), "state moved without a beat")
  `PLCA_CHECK(a_beacon_cmd, (tx_command == CMD_BEACON) == (state == ST_BEACON_TX), "beacon command outside beacon state")
  `PLCA_CHECK(a_committed, committed_flag |-> (state == ST_COMMIT || state == ST_TRANSMIT || state == ST_BURST || state == ST_ABORT), "committed outside a transmit opportunity")
  `PLCA_CHECK(a_disable_clear, (state == ST_DISABLE) |-> (!committed_flag && !active_flag && current_id == 8'd0 && tx_command == CMD_NONE), "DISABLE with live status")

endmodule

`default_nettype wire
